// File: src/vdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdr_pkg
// Shared types, sizes and helpers for the vertex dedup / remap block.
// ----------------------------------------------------------------------------
package vdr_pkg;

    localparam int MAX_UNIQUE = 1024;
    localparam int MAX_VERTS  = 4096;
    localparam int NCELL      = 8;
    localparam int ROWS       = MAX_UNIQUE / NCELL;

    localparam int CELL_W = $clog2(NCELL);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int UIDX_W = $clog2(MAX_UNIQUE);
    localparam int VIDX_W = $clog2(MAX_VERTS);
    localparam int UCNT_W = $clog2(MAX_UNIQUE + 1);
    localparam int VCNT_W = $clog2(MAX_VERTS + 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_REMAP = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_UNSEEN   = 2'd2,
        ST_TOO_MANY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RWAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_vertex;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic [11:0] face_index;
    } t_in;

    typedef struct packed {
        logic [9:0]  new_index;
        logic        is_new;
        logic [1:0]  status;
        logic [10:0] unique_count;
        logic [12:0] vertex_count;
    } t_out;

    // bit-exact compare, except +0 and -0 are equal
    function automatic logic coord_eq(input logic [31:0] a, input logic [31:0] b);
        coord_eq = (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
    endfunction

endpackage
`default_nettype wire

// File: src/vdr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// File: src/vdr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdr_cell
// One match cell: a bank of unique vertices, a comparator and the
// first-hit link to the next cell in the row.
// ----------------------------------------------------------------------------
module vdr_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [vdr_pkg::ROW_W-1:0]     i_wr_addr,
    input  wire vdr_pkg::t_vertex              i_wr_data,
    input  wire logic [vdr_pkg::ROW_W-1:0]     i_rd_addr,
    input  wire vdr_pkg::t_vertex              i_query,
    input  wire logic                          i_entry_ok,
    input  wire logic                          i_prev_hit,
    output logic                               o_first,
    output logic                               o_hit
);
    import vdr_pkg::*;

    t_vertex rd_data;
    logic    match;

    vdr_ram #(.WIDTH($bits(t_vertex)), .DEPTH(ROWS)) u_bank (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    assign match   = i_entry_ok && coord_eq(rd_data.x, i_query.x)
                     && coord_eq(rd_data.y, i_query.y) && coord_eq(rd_data.z, i_query.z);
    assign o_first = match && !i_prev_hit;
    assign o_hit   = match || i_prev_hit;
endmodule
`default_nettype wire

// File: src/vertex_dedup_remap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_dedup_remap
// Exact vertex dedup with remap table.
// ----------------------------------------------------------------------------
// One request at a time. Unique vertices are spread over a row of 8 match
// cells (vertex i sits in cell i mod 8); an add scans one row of 8 stored
// vertices per cycle and stops at the first hit. An add into an empty table
// or past the vertex limit, a clear and the unused command skip the row scan;
// a remap waits for the remap RAM read. A result waits in the output
// register; the next request is taken once the block is back in idle, and a
// stalled result holds the next request in its finish state until taken.
module vertex_dedup_remap (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire vdr_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output vdr_pkg::t_out      o_out_data
);
    import vdr_pkg::*;

    t_state r_state, n_state;
    t_in    r_req;
    logic [UCNT_W-1:0] r_unique;
    logic [VCNT_W-1:0] r_seen;
    logic [ROW_W:0]    r_row;
    logic              r_chk;
    logic [ROW_W-1:0]  r_chk_row;
    logic              r_hit;
    logic [UIDX_W-1:0] r_found;
    logic              r_out_valid;
    t_out              r_out;

    logic [ROW_W:0]    rows_used;
    logic [NCELL:0]    chain;
    logic [NCELL-1:0]  first;
    logic [CELL_W-1:0] hit_cell;
    logic [NCELL-1:0]  cell_wr;
    logic              new_wr, remap_wr, out_free, accept;
    logic [UIDX_W-1:0] remap_rd;
    t_vertex           query;
    t_out              res;
    logic [UCNT_W-1:0] n_unique;
    logic [VCNT_W-1:0] n_seen;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign rows_used = (ROW_W+1)'(((UCNT_W+1)'(r_unique) + (UCNT_W+1)'(NCELL - 1)) >> CELL_W);
    assign query     = '{x: r_req.coord_x, y: r_req.coord_y, z: r_req.coord_z};
    assign chain[0]  = 1'b0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        logic entry_ok;
        assign entry_ok = r_chk
            && ((UCNT_W+1)'({r_chk_row, CELL_W'(k)}) < (UCNT_W+1)'(r_unique));
        assign cell_wr[k] = new_wr && (r_unique[CELL_W-1:0] == CELL_W'(k));
        vdr_cell u_cell (
            .i_clk      (i_clk),
            .i_wr_en    (cell_wr[k]),
            .i_wr_addr  (r_unique[CELL_W +: ROW_W]),
            .i_wr_data  (query),
            .i_rd_addr  (r_row[ROW_W-1:0]),
            .i_query    (query),
            .i_entry_ok (entry_ok),
            .i_prev_hit (chain[k]),
            .o_first    (first[k]),
            .o_hit      (chain[k+1])
        );
    end

    always_comb begin
        hit_cell = '0;
        for (int k = 0; k < NCELL; k++) begin
            if (first[k]) hit_cell = hit_cell | CELL_W'(k);
        end
    end

    vdr_ram #(.WIDTH(UIDX_W), .DEPTH(MAX_VERTS)) u_remap (
        .i_clk     (i_clk),
        .i_wr_en   (remap_wr),
        .i_wr_addr (r_seen[VIDX_W-1:0]),
        .i_wr_data (new_wr ? r_unique[UIDX_W-1:0] : r_found),
        .i_rd_addr (r_req.face_index[VIDX_W-1:0]),
        .o_rd_data (remap_rd)
    );

    // result and table updates of the finishing cycle
    always_comb begin
        res      = '0;
        new_wr   = 1'b0;
        remap_wr = 1'b0;
        n_unique = r_unique;
        n_seen   = r_seen;
        case (r_req.cmd)
            CMD_ADD: begin
                if (r_seen == VCNT_W'(MAX_VERTS)) begin
                    res.status = ST_TOO_MANY;
                end else if (r_hit) begin
                    res.new_index = r_found;
                    remap_wr = 1'b1;
                    n_seen   = r_seen + 1'b1;
                end else if (r_unique == UCNT_W'(MAX_UNIQUE)) begin
                    res.status = ST_FULL;
                end else begin
                    res.new_index = r_unique[UIDX_W-1:0];
                    res.is_new = 1'b1;
                    new_wr   = 1'b1;
                    remap_wr = 1'b1;
                    n_unique = r_unique + 1'b1;
                    n_seen   = r_seen + 1'b1;
                end
            end
            CMD_REMAP: begin
                if (VCNT_W'(r_req.face_index) >= r_seen) begin
                    res.status = ST_UNSEEN;
                end else begin
                    res.new_index = remap_rd;
                end
            end
            CMD_CLEAR: begin
                n_unique = '0;
                n_seen   = '0;
            end
            default: ;
        endcase
        res.unique_count = n_unique;
        res.vertex_count = n_seen;
        if (!(r_state == S_FIN && out_free)) begin
            new_wr   = 1'b0;
            remap_wr = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.cmd == CMD_ADD && r_seen != VCNT_W'(MAX_VERTS)
                        && r_unique != '0) begin
                        n_state = S_SEARCH;
                    end else if (i_in_data.cmd == CMD_REMAP) begin
                        n_state = S_RWAIT;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SEARCH: begin
                if (r_chk && (chain[NCELL] || r_chk_row == rows_used[ROW_W-1:0] - 1'b1
                    || rows_used == '0)) begin
                    n_state = S_FIN;
                end
            end
            S_RWAIT: n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_unique    <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_req <= i_in_data;
                r_row <= '0;
                r_chk <= 1'b0;
                r_hit <= 1'b0;
            end
            if (r_state == S_SEARCH) begin
                if (r_row < rows_used) begin
                    r_row     <= r_row + 1'b1;
                    r_chk     <= 1'b1;
                    r_chk_row <= r_row[ROW_W-1:0];
                end else begin
                    r_chk <= 1'b0;
                end
                if (r_chk && chain[NCELL]) begin
                    r_hit   <= 1'b1;
                    r_found <= {r_chk_row, hit_cell};
                end
            end
            if (r_state == S_FIN && out_free) begin
                r_unique    <= n_unique;
                r_seen      <= n_seen;
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// File: src/vdr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdr_checker
// Port-level checks for vertex_dedup_remap, bound to the top level.
// ----------------------------------------------------------------------------
module vdr_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire vdr_pkg::t_out o_out_data
);
    import vdr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // one request in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.unique_count <= 11'(MAX_UNIQUE))
            && (13'(o_out_data.unique_count) <= o_out_data.vertex_count))
        else $error("count out of range");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_new |-> o_out_data.status == ST_OK)
        else $error("new vertex with error status");
endmodule

bind vertex_dedup_remap vdr_checker u_vdr_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, remap, clear and unused requests into vertex_dedup_remap with
// random gaps and output stalls, predicts every response and compares it
// field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import vdr_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    vertex_dedup_remap i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predicted block state
    logic [31:0] mesh_x [MAX_UNIQUE];
    logic [31:0] mesh_y [MAX_UNIQUE];
    logic [31:0] mesh_z [MAX_UNIQUE];
    logic [9:0]  vert_map [MAX_VERTS];
    int          mesh_unique;
    int          mesh_seen;

    t_out pending_resp [$];
    int   error_count;
    int   resp_count;
    int   hold_cycles;
    bit   gaps_on;

    // recent vertices, reused to make duplicates
    logic [31:0] pool_x [$];
    logic [31:0] pool_y [$];
    logic [31:0] pool_z [$];

    function automatic bit same_coord(logic [31:0] a, logic [31:0] b);
        return (a == b) || (a[30:0] == 31'd0 && b[30:0] == 31'd0);
    endfunction

    function automatic t_out dedup_predict(t_in req);
        t_out r;
        int   hit;
        r = '0;
        case (t_cmd'(req.cmd))
            CMD_ADD: begin
                if (mesh_seen >= MAX_VERTS) begin
                    r.status = ST_TOO_MANY;
                end else begin
                    hit = -1;
                    for (int i = 0; i < mesh_unique; i++) begin
                        if (hit < 0 && same_coord(mesh_x[i], req.coord_x) &&
                            same_coord(mesh_y[i], req.coord_y) &&
                            same_coord(mesh_z[i], req.coord_z))
                            hit = i;
                    end
                    if (hit >= 0) begin
                        vert_map[mesh_seen] = hit[9:0];
                        mesh_seen++;
                        r.new_index = hit[9:0];
                    end else if (mesh_unique >= MAX_UNIQUE) begin
                        r.status = ST_FULL;
                    end else begin
                        mesh_x[mesh_unique] = req.coord_x;
                        mesh_y[mesh_unique] = req.coord_y;
                        mesh_z[mesh_unique] = req.coord_z;
                        vert_map[mesh_seen] = mesh_unique[9:0];
                        r.new_index = mesh_unique[9:0];
                        r.is_new    = 1'b1;
                        mesh_unique++;
                        mesh_seen++;
                    end
                end
            end
            CMD_REMAP: begin
                if (req.face_index >= mesh_seen) r.status = ST_UNSEEN;
                else r.new_index = vert_map[req.face_index];
            end
            CMD_CLEAR: begin
                mesh_unique = 0;
                mesh_seen   = 0;
            end
            default: ;
        endcase
        r.unique_count = mesh_unique[10:0];
        r.vertex_count = mesh_seen[12:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR: response %0d %s got %0d expected %0d", resp_count, what, got, want);
        error_count++;
    endtask

    // valid stays up between back-to-back requests; it drops only for a gap
    task automatic send_request(t_in req);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_resp = {pending_resp, dedup_predict(req)};
        @(negedge i_clk);
    endtask

    // receiver: random stalls, or a long hold when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (gaps_on) begin
            i_out_stall <= ($urandom_range(0, 10) > $urandom_range(0, 10));
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("response while none pending", 1, 0);
            end else begin
                want = pending_resp.pop_front();
                if (o_out_data.new_index !== want.new_index)
                    report_mismatch("new_index", int'(o_out_data.new_index),
                                    int'(want.new_index));
                if (o_out_data.is_new !== want.is_new)
                    report_mismatch("is_new", int'(o_out_data.is_new), int'(want.is_new));
                if (o_out_data.status !== want.status)
                    report_mismatch("status", int'(o_out_data.status), int'(want.status));
                if (o_out_data.unique_count !== want.unique_count)
                    report_mismatch("unique_count", int'(o_out_data.unique_count),
                                    int'(want.unique_count));
                if (o_out_data.vertex_count !== want.vertex_count)
                    report_mismatch("vertex_count", int'(o_out_data.vertex_count),
                                    int'(want.vertex_count));
            end
            resp_count++;
        end
    end

    function automatic t_in make_add(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in r;
        r = '0;
        r.cmd = CMD_ADD;
        r.coord_x = x;
        r.coord_y = y;
        r.coord_z = z;
        r.face_index = 12'($urandom);
        return r;
    endfunction

    function automatic t_in make_cmd(t_cmd c, logic [11:0] fi);
        t_in r;
        r = '0;
        r.cmd = c;
        r.coord_x = $urandom;
        r.coord_y = $urandom;
        r.coord_z = $urandom;
        r.face_index = fi;
        return r;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7FC0_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_request(make_cmd(CMD_REMAP, 12'd0));
        send_request(make_add(32'h0000_0000, 32'h8000_0000, 32'h3F80_0000));
        send_request(make_add(32'h8000_0000, 32'h0000_0000, 32'h3F80_0000));
        send_request(make_add(32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001));
        send_request(make_add(32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001));
        send_request(make_add(32'h7FC0_0001, 32'hFFFF_FFFF, 32'h0000_0001));
        send_request(make_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_cmd(CMD_REMAP, 12'd1));
        send_request(make_cmd(CMD_REMAP, 12'd3));
        send_request(make_cmd(CMD_REMAP, 12'd5));
        send_request(make_cmd(CMD_REMAP, 12'hFFF));
        send_request(make_cmd(CMD_NOP, 12'hFFF));
        send_request(make_cmd(CMD_CLEAR, 12'd0));
        send_request(make_cmd(CMD_REMAP, 12'd0));
        send_request(make_add(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    endtask

    // fill the unique table, then hit full
    task automatic test_capacity();
        send_request(make_cmd(CMD_CLEAR, 12'd0));
        for (int i = 0; i < MAX_UNIQUE; i++)
            send_request(make_add(32'h4000_0000 + i, 32'h8000_0000, 32'(i)));
        send_request(make_add(32'h1234_5678, 32'h0, 32'h0));
        send_request(make_add(32'h4000_0000 + 1023, 32'h0, 32'd1023));
        send_request(make_add(32'h4000_0000, 32'h0, 32'd0));
        send_request(make_cmd(CMD_REMAP, 12'd1023));
        send_request(make_cmd(CMD_REMAP, 12'hFFF));
        send_request(make_cmd(CMD_REMAP, 12'd4094));
        send_request(make_cmd(CMD_CLEAR, 12'd0));
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 20; i++)
            send_request(make_add(pick_coord(), pick_coord(), pick_coord()));
    endtask

    task automatic test_random(int count);
        t_in  req;
        int   k;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0: req = make_cmd(CMD_CLEAR, 12'($urandom));
                1: req = make_cmd(CMD_NOP, 12'($urandom));
                2, 3, 4, 5:
                    req = make_cmd(CMD_REMAP, ($urandom_range(0, 7) == 0) ?
                        12'($urandom) : 12'($urandom_range(0, mesh_seen + 1)));
                6, 7, 8, 9, 10, 11: begin
                    if (pool_x.size() > 0) begin
                        k = $urandom_range(0, pool_x.size() - 1);
                        req = make_add(pool_x[k] ^ ($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 0),
                                       pool_y[k], pool_z[k]);
                    end else begin
                        req = make_add(pick_coord(), pick_coord(), pick_coord());
                    end
                end
                default: begin
                    req = make_add(pick_coord(), pick_coord(), pick_coord());
                    pool_x = {pool_x, req.coord_x};
                    pool_y = {pool_y, req.coord_y};
                    pool_z = {pool_z, req.coord_z};
                    if (pool_x.size() > 40) begin
                        void'(pool_x.pop_front());
                        void'(pool_y.pop_front());
                        void'(pool_z.pop_front());
                    end
                end
            endcase
            send_request(req);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        error_count = 0;
        resp_count  = 0;
        hold_cycles = 0;
        gaps_on     = 1'b1;
        mesh_unique = 0;
        mesh_seen   = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random(250);
        gaps_on = 1'b0;
        test_random(100);
        gaps_on = 1'b1;
        test_capacity();
        test_random(100);
        wait_drained();

        $display("Covered %0d responses: directed zero/NaN cases, table full,",
                 resp_count);
        $display("unseen remaps, clears, unused command, long output hold and random traffic.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("Timeout waiting for responses");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
